// ===== rtl/sobel_pkg.sv =====
`timescale 1ns / 1ps
package sobel_pkg;

  // Channels carried by one pixel, and the width of one packed pixel word
  localparam int unsigned ChanNum = 3;
  localparam int unsigned PixW    = 8 * ChanNum;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  // Register widths and limits
  localparam int unsigned WidthRegW  = 12;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned RowW       = 12;
  localparam int unsigned WidCmpW    = 14;
  localparam logic [HeightRegW-1:0] HeightLimit = 13'd4096;
  localparam logic [7:0] SatLimit = 8'd255;

  // One channel's 3x3 window: [row][col], rows top..bottom, cols left..right
  typedef logic [2:0][2:0][7:0] win_t;

  // Lane status toward the merge stage
  typedef struct packed {
    logic       done;
    logic [7:0] mag;
  } lane_st_t;

  // Merge stage control from the sequencer
  typedef struct packed {
    logic load;
    logic nonborder;
    logic last;
  } merge_ctl_t;

endpackage

// ===== rtl/sobel_if.sv =====
`timescale 1ns / 1ps
interface sobel_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;

  modport source (output valid, output chan_a, output chan_b, output chan_c, input ready);
  modport sink   (input valid, input chan_a, input chan_b, input chan_c, output ready);
endinterface

interface sobel_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_value;
  logic       frame_last;

  modport source (output valid, output edge_value, output frame_last, input ready);
  modport sink   (input valid, input edge_value, input frame_last, output ready);
endinterface

// ===== rtl/sobel_lane.sv =====
`timescale 1ns / 1ps
module sobel_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sobel_pkg::win_t   win_i,
  output sobel_pkg::lane_st_t status_o
);

  typedef enum logic [1:0] {
    L_IDLE,
    L_SQ,
    L_ROOT
  } lane_state_e;

  lane_state_e state_q;
  logic [7:0]  ay_q, ax_q;
  logic [16:0] rem_q;
  logic [17:0] root_q;
  logic [3:0]  cnt_q;
  logic        done_q;
  logic [7:0]  mag_q;

  logic [9:0]         top_sum, bot_sum, lft_sum, rgt_sum;
  logic signed [10:0] gy, gx;
  logic [10:0]        gy_abs, gx_abs;
  logic [7:0]         ay_d, ax_d;
  logic [17:0]        bit_w, trial, root_d;
  logic [16:0]        rem_d;
  logic [16:0]        sq_sum;

  // Kernel sums: vertical kernel on rows, horizontal kernel on columns
  assign top_sum = {2'b0, win_i[0][0]} + {1'b0, win_i[0][1], 1'b0} + {2'b0, win_i[0][2]};
  assign bot_sum = {2'b0, win_i[2][0]} + {1'b0, win_i[2][1], 1'b0} + {2'b0, win_i[2][2]};
  assign lft_sum = {2'b0, win_i[0][0]} + {1'b0, win_i[1][0], 1'b0} + {2'b0, win_i[2][0]};
  assign rgt_sum = {2'b0, win_i[0][2]} + {1'b0, win_i[1][2], 1'b0} + {2'b0, win_i[2][2]};

  assign gy = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
  assign gx = $signed({1'b0, lft_sum}) - $signed({1'b0, rgt_sum});

  // Absolute value, saturated to one byte
  assign gy_abs = gy[10] ? 11'(-gy) : 11'(gy);
  assign gx_abs = gx[10] ? 11'(-gx) : 11'(gx);
  assign ay_d   = (|gy_abs[10:8]) ? sobel_pkg::SatLimit : gy_abs[7:0];
  assign ax_d   = (|gx_abs[10:8]) ? sobel_pkg::SatLimit : gx_abs[7:0];

  // Sum of squares
  assign sq_sum = {1'b0, 16'(ay_q * ay_q)} + {1'b0, 16'(ax_q * ax_q)};

  // One step of the digit-by-digit square root
  always_comb begin
    bit_w  = 18'd1 << {cnt_q, 1'b0};
    trial  = root_q + bit_w;
    rem_d  = rem_q;
    root_d = root_q >> 1;
    if ({1'b0, rem_q} >= trial) begin
      rem_d  = 17'({1'b0, rem_q} - trial);
      root_d = (root_q >> 1) + bit_w;
    end
  end

  // Sequence: take |gy|,|gx|, square, then nine root steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            ay_q    <= ay_d;
            ax_q    <= ax_d;
            state_q <= L_SQ;
          end
        end
        L_SQ: begin
          rem_q   <= sq_sum;
          root_q  <= '0;
          cnt_q   <= 4'd8;
          state_q <= L_ROOT;
        end
        L_ROOT: begin
          rem_q  <= rem_d;
          root_q <= root_d;
          cnt_q  <= cnt_q - 4'd1;
          if (cnt_q == 4'd0) begin
            mag_q   <= (root_d > 18'd255) ? sobel_pkg::SatLimit : root_d[7:0];
            done_q  <= 1'b1;
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign status_o.done = done_q;
  assign status_o.mag  = mag_q;

endmodule

// ===== rtl/sobel_merge.sv =====
`timescale 1ns / 1ps
module sobel_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sobel_pkg::merge_ctl_t             ctl_i,
  input  sobel_pkg::lane_st_t [sobel_pkg::ChanNum-1:0] lanes_i,
  output logic                              free_o,
  sobel_out_if.source                       out_ch
);

  logic       valid_q;
  logic [7:0] edge_q;
  logic       last_q;
  logic [7:0] max_ab, max_abc;

  // Largest magnitude over the channels
  assign max_ab  = (lanes_i[1].mag > lanes_i[0].mag) ? lanes_i[1].mag : lanes_i[0].mag;
  assign max_abc = (lanes_i[2].mag > max_ab) ? lanes_i[2].mag : max_ab;

  assign free_o = !valid_q || out_ch.ready;

  // Hold the request until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      edge_q <= ctl_i.nonborder ? max_abc : 8'd0;
      last_q <= ctl_i.last;
    end
  end

  assign out_ch.valid      = valid_q;
  assign out_ch.edge_value = edge_q;
  assign out_ch.frame_last = last_q;

endmodule

// ===== rtl/sobel_edge_rgb_max.sv =====
`timescale 1ns / 1ps
// Each accepted pixel passes in order through the store read, the lane capture of
// |gy| and |gx|, squaring, nine square root steps in each channel lane, the done
// handoff and the merge load; the input takes no new pixel until the sequencer is
// back in idle, and a stalled earlier result holds the sequencer until it is taken.
// Reset (rst_ni, asynchronous, active low) clears counters, window columns and
// the handshake state; the line stores hold no reset, and border results are zero.
module sobel_edge_rgb_max #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sobel_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sobel_pkg::CfgDataW-1:0]  cfg_data_i,
  sobel_in_if.sink                        in_ch,
  sobel_out_if.source                     out_ch
);

  localparam int unsigned ColW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [sobel_pkg::WidCmpW-1:0] MaxWid = sobel_pkg::WidCmpW'(MAX_WIDTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_OUT
  } seq_state_e;

  seq_state_e                        state_q;
  logic [sobel_pkg::WidthRegW-1:0]   width_q;
  logic [sobel_pkg::HeightRegW-1:0]  height_q;
  logic [ColW-1:0]                   col_q, idx_q;
  logic [sobel_pkg::RowW-1:0]        row_q;
  logic [sobel_pkg::PixW-1:0]        pix_q;
  logic                              emit_q, nonborder_q, last_q;
  logic [2:0][sobel_pkg::PixW-1:0]   w1_q, w2_q;
  logic [2*sobel_pkg::PixW-1:0]      rd_q;
  logic [2*sobel_pkg::PixW-1:0]      mem [0:MAX_WIDTH-1];

  logic [sobel_pkg::WidCmpW-1:0]     wid_ext, wid, col_ext;
  logic [sobel_pkg::HeightRegW-1:0]  hgt, row_ext;
  logic                              accept, row_end, frame_end;
  logic [2:0][sobel_pkg::PixW-1:0]   right_col;
  sobel_pkg::win_t [sobel_pkg::ChanNum-1:0]   lane_win;
  sobel_pkg::lane_st_t [sobel_pkg::ChanNum-1:0] lane_st;
  sobel_pkg::merge_ctl_t             merge_ctl;
  logic                              merge_free;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd640;
      height_q <= 13'd480;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sobel_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[sobel_pkg::WidthRegW-1:0];
        sobel_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the image size
  assign wid_ext = sobel_pkg::WidCmpW'(width_q);
  assign wid = (wid_ext < 14'd3) ? 14'd3 : ((wid_ext > MaxWid) ? MaxWid : wid_ext);
  assign hgt = (height_q < 13'd3) ? 13'd3 :
               ((height_q > sobel_pkg::HeightLimit) ? sobel_pkg::HeightLimit : height_q);

  assign col_ext   = sobel_pkg::WidCmpW'(col_q);
  assign row_ext   = sobel_pkg::HeightRegW'(row_q);
  assign row_end   = (col_ext + 14'd1) >= wid;
  assign frame_end = (row_ext + 13'd1) >= hgt;
  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == S_IDLE);

  // Line stores: upper row in the low half, lower row in the high half
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[col_q];
    end
    if (state_q == S_READ) begin
      mem[idx_q] <= {pix_q, rd_q[2*sobel_pkg::PixW-1:sobel_pkg::PixW]};
    end
  end

  // Right window column: rows r-2, r-1 from the stores, row r is the pixel
  assign right_col[0] = rd_q[sobel_pkg::PixW-1:0];
  assign right_col[1] = rd_q[2*sobel_pkg::PixW-1:sobel_pkg::PixW];
  assign right_col[2] = pix_q;

  // Split the window by channel for the lanes
  always_comb begin
    for (int ch = 0; ch < sobel_pkg::ChanNum; ch++) begin
      for (int r = 0; r < 3; r++) begin
        lane_win[ch][r][0] = w2_q[r][8*ch +: 8];
        lane_win[ch][r][1] = w1_q[r][8*ch +: 8];
        lane_win[ch][r][2] = right_col[r][8*ch +: 8];
      end
    end
  end

  // Sequencer: accept, read stores, run lanes, hand a due result to merge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      idx_q       <= '0;
      pix_q       <= '0;
      emit_q      <= 1'b0;
      nonborder_q <= 1'b0;
      last_q      <= 1'b0;
      w1_q        <= '0;
      w2_q        <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q       <= col_q;
            pix_q       <= {in_ch.chan_c, in_ch.chan_b, in_ch.chan_a};
            emit_q      <= (row_q != '0) && (col_q != '0);
            nonborder_q <= (row_q >= 12'd2) && (col_ext >= 14'd2);
            last_q      <= (row_ext == hgt - 13'd1) && (col_ext == wid - 14'd1);
            if (row_end) begin
              col_q <= '0;
              row_q <= frame_end ? '0 : row_q + 12'd1;
            end else begin
              col_q <= col_q + ColW'(1);
            end
            state_q <= S_READ;
          end
        end
        S_READ: begin
          w2_q    <= w1_q;
          w1_q    <= right_col;
          state_q <= S_CALC;
        end
        S_CALC: begin
          if (lane_st[0].done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!emit_q || merge_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Channel lanes
  for (genvar ch = 0; ch < sobel_pkg::ChanNum; ch++) begin : g_lane
    sobel_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .start_i  (state_q == S_READ),
      .win_i    (lane_win[ch]),
      .status_o (lane_st[ch])
    );
  end

  assign merge_ctl.load      = (state_q == S_OUT) && emit_q && merge_free;
  assign merge_ctl.nonborder = nonborder_q;
  assign merge_ctl.last      = last_q;

  sobel_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (merge_ctl),
    .lanes_i (lane_st),
    .free_o  (merge_free),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/sobel_chk.sv =====
`timescale 1ns / 1ps
module sobel_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_edge_i,
  input logic       out_last_i
);

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_edge_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // An accepted pixel keeps the input closed while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("input reopened too early");

  // A new result only follows busy cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i, 1) && $past(!in_ready_i, 2))
    else $error("result appeared without work");

endmodule

bind sobel_edge_rgb_max sobel_chk u_sobel_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_edge_i  (out_ch.edge_value),
  .out_last_i  (out_ch.frame_last)
);

// ===== test/tb_sobel_edge_rgb_max.sv =====
`timescale 1ns / 1ps
module tb_sobel_edge_rgb_max;

  localparam int MAX_W        = 2048;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 24;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RAND_ITEMS   = 200;

  typedef struct packed {
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
  } pixel_t;

  typedef struct packed {
    logic [7:0] edge_value;
    logic       frame_last;
  } edge_res_t;

  typedef enum logic [1:0] {FILL_NOISE, FILL_RAILS, FILL_RAMP} fill_e;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [sobel_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [sobel_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  sobel_in_if  pix_if ();
  sobel_out_if edge_if ();

  sobel_edge_rgb_max #(
    .MAX_WIDTH (MAX_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_ch       (pix_if.sink),
    .out_ch      (edge_if.source)
  );

  // Pixels waiting to be offered, and edge results still due from the block
  pixel_t    pix_q[$];
  edge_res_t edge_due_q[$];

  // Shadow of the block state for prediction
  logic [23:0]     row_upper [MAX_W] = '{default: '0};
  logic [23:0]     row_lower [MAX_W] = '{default: '0};
  logic [23:0]     win_col   [6]     = '{default: '0};
  int              col_pos    = 0;
  int              row_pos    = 0;
  logic [11:0]     cfg_width  = 12'd640;
  logic [12:0]     cfg_height = 13'd480;

  bit idle_en  = 1'b1;
  bit hold_req = 1'b0;
  int fail_cnt = 0;
  int send_gap;
  int stall_left;
  int hold_left;
  bit hold_done;
  int quiet_cycles;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int eff_width(input int v);
    return (v < 3) ? 3 : ((v > MAX_W) ? MAX_W : v);
  endfunction

  function automatic int eff_height(input int v);
    return (v < 3) ? 3 : ((v > 4096) ? 4096 : v);
  endfunction

  // Clamped Sobel magnitude of one channel window
  function automatic logic [7:0] channel_edge(input sobel_pkg::win_t w);
    int gy, gx, ay, ax, sq, root;
    gy = (int'(w[0][0]) + 2 * int'(w[0][1]) + int'(w[0][2]))
       - (int'(w[2][0]) + 2 * int'(w[2][1]) + int'(w[2][2]));
    gx = (int'(w[0][0]) + 2 * int'(w[1][0]) + int'(w[2][0]))
       - (int'(w[0][2]) + 2 * int'(w[1][2]) + int'(w[2][2]));
    ay = (gy < 0) ? -gy : gy;
    ax = (gx < 0) ? -gx : gx;
    if (ay > 255) ay = 255;
    if (ax > 255) ax = 255;
    sq = ay * ay + ax * ax;
    root = 0;
    while ((root + 1) * (root + 1) <= sq) root++;
    if (root > 255) root = 255;
    return 8'(root);
  endfunction

  // Advance the shadow state by one accepted pixel and queue its result, if any
  function automatic void predict_edge(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [23:0]     px, top, mid;
    logic [23:0]     taps [3][3];
    sobel_pkg::win_t w;
    logic [7:0]      best, m;
    edge_res_t       res;
    int              wid, hgt, idx;
    wid = eff_width(int'(cfg_width));
    hgt = eff_height(int'(cfg_height));
    idx = col_pos % MAX_W;
    px  = {c, b, a};
    top = row_upper[idx];
    mid = row_lower[idx];
    for (int i = 0; i < 3; i++) begin
      taps[i][0] = win_col[3 + i];
      taps[i][1] = win_col[i];
    end
    taps[0][2] = top;
    taps[1][2] = mid;
    taps[2][2] = px;
    if (row_pos >= 1 && col_pos >= 1) begin
      best = 8'd0;
      // border pixels of the image stay zero
      if (row_pos >= 2 && col_pos >= 2) begin
        for (int ch = 0; ch < 3; ch++) begin
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
              w[i][j] = taps[i][j][8 * ch +: 8];
          m = channel_edge(w);
          if (m > best) best = m;
        end
      end
      res.edge_value = best;
      res.frame_last = (row_pos == hgt - 1) && (col_pos == wid - 1);
      edge_due_q.push_back(res);
    end
    row_upper[idx] = mid;
    row_lower[idx] = px;
    for (int i = 0; i < 3; i++) begin
      win_col[3 + i] = win_col[i];
      win_col[i]     = taps[i][2];
    end
    // wrap the column at the row end, and the row at the frame end
    if (col_pos + 1 >= wid) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= hgt) ? 0 : ((row_pos + 1) % 4096);
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Pixel driver: offer queued requests, with random gaps while idle_en is set
  always @(posedge clk_i or negedge rst_ni) begin : drive_pixels
    pixel_t nxt;
    if (!rst_ni) begin
      pix_if.valid  <= 1'b0;
      pix_if.chan_a <= '0;
      pix_if.chan_b <= '0;
      pix_if.chan_c <= '0;
      send_gap      <= 0;
    end else begin
      if (pix_if.valid && pix_if.ready)
        predict_edge(pix_if.chan_a, pix_if.chan_b, pix_if.chan_c);
      if (!pix_if.valid || pix_if.ready) begin
        if (send_gap > 0) begin
          send_gap     <= send_gap - 1;
          pix_if.valid <= 1'b0;
        end else if (pix_q.size() == 0) begin
          pix_if.valid <= 1'b0;
        end else if (idle_en && hold_left == 0 && $urandom_range(0, 7) == 0) begin
          send_gap     <= $urandom_range(0, 15);
          pix_if.valid <= 1'b0;
        end else begin
          nxt = pix_q.pop_front();
          pix_if.valid  <= 1'b1;
          pix_if.chan_a <= nxt.chan_a;
          pix_if.chan_b <= nxt.chan_b;
          pix_if.chan_c <= nxt.chan_c;
        end
      end
    end
  end

  // Result monitor: compare each accepted result, then drive ready
  always @(posedge clk_i or negedge rst_ni) begin : check_edges
    edge_res_t want;
    if (!rst_ni) begin
      edge_if.ready <= 1'b0;
      stall_left    <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else begin
      if (edge_if.valid && edge_if.ready) begin
        if (edge_due_q.size() == 0) begin
          fail_cnt++;
          $display("%0t unexpected result: expected none, actual edge_value %0d frame_last %0d",
                   $time, edge_if.edge_value, edge_if.frame_last);
        end else begin
          want = edge_due_q.pop_front();
          if (edge_if.edge_value !== want.edge_value) begin
            fail_cnt++;
            $display("%0t edge_value mismatch: expected %0d, actual %0d",
                     $time, want.edge_value, edge_if.edge_value);
          end
          if (edge_if.frame_last !== want.frame_last) begin
            fail_cnt++;
            $display("%0t frame_last mismatch: expected %0d, actual %0d",
                     $time, want.frame_last, edge_if.frame_last);
          end
        end
      end
      // hold off once for a long stretch so the block backs up into its input
      if (hold_req && !hold_done) begin
        hold_done     <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        edge_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        edge_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        edge_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left    <= $urandom_range(0, 15);
        edge_if.ready <= 1'b0;
      end else begin
        edge_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((pix_if.valid && pix_if.ready) || (edge_if.valid && edge_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [sobel_pkg::CfgIdxW-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= sobel_pkg::CfgDataW'(val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == sobel_pkg::CFG_IMAGE_WIDTH) cfg_width = 12'(val);
    else cfg_height = 13'(val);
  endtask

  // Wait until every request is taken and every result is back, then let the block settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pix_q.size() != 0 || pix_if.valid || edge_due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Queue a run of raster pixels with the given content style
  task automatic queue_run(input int count, input int w, input fill_e fill);
    int         base [3];
    int         dx [3];
    int         dy [3];
    int         r, c;
    logic [7:0] v [3];
    for (int k = 0; k < 3; k++) begin
      base[k] = $urandom_range(0, 255);
      dx[k]   = $urandom_range(0, 48);
      dy[k]   = $urandom_range(0, 48);
    end
    for (int n = 0; n < count; n++) begin
      r = n / w;
      c = n % w;
      for (int k = 0; k < 3; k++) begin
        case (fill)
          FILL_NOISE: v[k] = 8'($urandom_range(0, 255));
          FILL_RAILS: v[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default:    v[k] = 8'(base[k] + r * dy[k] + c * dx[k] + $urandom_range(0, 3));
        endcase
      end
      pix_q.push_back(pixel_t'{v[0], v[1], v[2]});
    end
  endtask

  initial begin : run_phases
    int    w_reg, h_reg, frames, queued;
    fill_e fill;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 3x3 frames through the low clamps of both registers
    write_reg(sobel_pkg::CFG_IMAGE_WIDTH, 0);
    write_reg(sobel_pkg::CFG_IMAGE_HEIGHT, 2);
    // saturating vertical step on a, weak horizontal step on b, flat c
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        pix_q.push_back(pixel_t'{(r == 0) ? 8'hFF : 8'h00, (c == 0) ? 8'd10 : 8'd0, 8'd0});
    // negative horizontal step on c wins the channel maximum
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        pix_q.push_back(pixel_t'{8'd7, (c == 0) ? 8'd10 : 8'd0, (c == 2) ? 8'd30 : 8'd0});
    // full-scale flat a and b, upward saturating step on c
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        pix_q.push_back(pixel_t'{8'hFF, 8'hFF, (r == 2) ? 8'hFF : 8'h00});
    wait_drained();

    // Random frames of small sizes, clamped values now and then
    queued = 0;
    while (queued < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w_reg = $urandom_range(0, 2);
        1:       w_reg = $urandom_range(17, 40);
        default: w_reg = $urandom_range(3, 16);
      endcase
      h_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      write_reg(sobel_pkg::CFG_IMAGE_WIDTH, w_reg);
      write_reg(sobel_pkg::CFG_IMAGE_HEIGHT, h_reg);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        fill = fill_e'($urandom_range(0, 2));
        queue_run(eff_width(w_reg) * eff_height(h_reg), eff_width(w_reg), fill);
        queued += eff_width(w_reg) * eff_height(h_reg);
      end
      wait_drained();
    end

    // Raise the height in the middle of a frame
    write_reg(sobel_pkg::CFG_IMAGE_WIDTH, 6);
    write_reg(sobel_pkg::CFG_IMAGE_HEIGHT, 3);
    queue_run(8, 6, FILL_NOISE);
    wait_drained();
    write_reg(sobel_pkg::CFG_IMAGE_HEIGHT, 6);
    queue_run(28, 6, FILL_RAMP);
    wait_drained();

    // Drop the height below the current row: the frame ends with no last flag
    write_reg(sobel_pkg::CFG_IMAGE_WIDTH, 5);
    write_reg(sobel_pkg::CFG_IMAGE_HEIGHT, 12);
    queue_run(25, 5, FILL_NOISE);
    wait_drained();
    write_reg(sobel_pkg::CFG_IMAGE_HEIGHT, 4);
    queue_run(5, 5, FILL_NOISE);
    queue_run(20, 5, FILL_RAILS);
    wait_drained();

    // Widest row at the high clamps, with the long receiver hold-off
    write_reg(sobel_pkg::CFG_IMAGE_WIDTH, 4095);
    write_reg(sobel_pkg::CFG_IMAGE_HEIGHT, 8191);
    queue_run(MAX_W + 30, MAX_W, FILL_NOISE);
    hold_req = 1'b1;
    wait_drained();
    // shrink the width mid-row; the frame then closes at row 4
    write_reg(sobel_pkg::CFG_IMAGE_WIDTH, 4);
    write_reg(sobel_pkg::CFG_IMAGE_HEIGHT, 5);
    queue_run(13, 4, FILL_NOISE);
    wait_drained();

    // Last part at full rate on both sides
    idle_en = 1'b0;
    write_reg(sobel_pkg::CFG_IMAGE_WIDTH, 16);
    write_reg(sobel_pkg::CFG_IMAGE_HEIGHT, 5);
    queue_run(80, 16, FILL_RAMP);
    queue_run(80, 16, FILL_NOISE);
    wait_drained();

    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sobel_pkg.sv
rtl/sobel_if.sv
rtl/sobel_lane.sv
rtl/sobel_merge.sv
rtl/sobel_edge_rgb_max.sv
rtl/sobel_chk.sv
test/tb_sobel_edge_rgb_max.sv
